// File: src/asio_pkg.sv
package asio_pkg;

	// Command codes
	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_PRESS   = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	// Port numbers
	localparam logic [7:0] PORT_FIXED   = 8'd0;
	localparam logic [7:0] PORT_BTN_ONE = 8'd1;
	localparam logic [7:0] PORT_BTN_TWO = 8'd2;
	localparam logic [7:0] PORT_SHIFT   = 8'd3;
	localparam logic [7:0] PORT_OFFSET  = 8'd2;
	localparam logic [7:0] PORT_OUT_A   = 8'd3;
	localparam logic [7:0] PORT_SHIFT_LOAD = 8'd4;
	localparam logic [7:0] PORT_OUT_B   = 8'd5;
	localparam logic [7:0] PORT_OUT_C   = 8'd6;

	// Reset values
	localparam logic [7:0] PORT0_RESET   = 8'b0000_1110;
	localparam logic [7:0] BTN_ONE_RESET = 8'b0000_1000;

	// Button codes
	localparam logic [3:0] BTN_COIN     = 4'd0;
	localparam logic [3:0] BTN_P2_START = 4'd1;
	localparam logic [3:0] BTN_P1_START = 4'd2;
	localparam logic [3:0] BTN_P1_SHOOT = 4'd3;
	localparam logic [3:0] BTN_P1_LEFT  = 4'd4;
	localparam logic [3:0] BTN_P1_RIGHT = 4'd5;
	localparam logic [3:0] BTN_P2_SHOOT = 4'd6;
	localparam logic [3:0] BTN_P2_LEFT  = 4'd7;
	localparam logic [3:0] BTN_P2_RIGHT = 4'd8;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] port_number;
		logic [7:0] write_data;
		logic [3:0] button_code;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_hit;
		logic [7:0] sound_latch_a;
		logic [7:0] sound_latch_b;
		logic [7:0] latch_port_six;
	} res_item_t;

	// Hand-off between the request register and the core
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctrl_t;

	typedef struct packed {
		logic       to_one;
		logic       to_two;
		logic [7:0] mask;
	} btn_sel_t;

	// Map a button code to its latch and bit
	function automatic btn_sel_t button_map(input logic [3:0] code);
		btn_sel_t sel;
		sel = '0;
		unique case (code)
			BTN_COIN:     begin sel.to_one = 1'b1; sel.mask = 8'h01; end
			BTN_P2_START: begin sel.to_one = 1'b1; sel.mask = 8'h02; end
			BTN_P1_START: begin sel.to_one = 1'b1; sel.mask = 8'h04; end
			BTN_P1_SHOOT: begin sel.to_one = 1'b1; sel.mask = 8'h10; end
			BTN_P1_LEFT:  begin sel.to_one = 1'b1; sel.mask = 8'h20; end
			BTN_P1_RIGHT: begin sel.to_one = 1'b1; sel.mask = 8'h40; end
			BTN_P2_SHOOT: begin sel.to_two = 1'b1; sel.mask = 8'h10; end
			BTN_P2_LEFT:  begin sel.to_two = 1'b1; sel.mask = 8'h20; end
			BTN_P2_RIGHT: begin sel.to_two = 1'b1; sel.mask = 8'h40; end
			default:      sel = '0;
		endcase
		return sel;
	endfunction

endpackage

// File: src/asio_in_stage.sv
module asio_in_stage import asio_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_item_t   cmd,
	input  logic        advance,
	output stage_ctrl_t ctrl,
	output cmd_item_t   item_s1
);

	logic valid_s1;

	// Take a new request when the register is empty or the held one moves on this cycle
	assign cmd_ready    = !valid_s1 || advance;
	assign ctrl.valid   = valid_s1;
	assign ctrl.advance = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Hold the request payload
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

endmodule

// File: src/asio_core.sv
module asio_core import asio_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  stage_ctrl_t ctrl,
	input  cmd_item_t   item_s1,
	output res_item_t   res_next
);

	logic [7:0]  port0_q;
	logic [15:0] shift_word_q;
	logic [2:0]  shift_offset_q;
	logic [7:0]  buttons_one_q;
	logic [7:0]  buttons_two_q;
	logic [7:0]  out_three_q;
	logic [7:0]  out_five_q;
	logic [7:0]  out_six_q;

	logic [15:0] shifted;
	logic [3:0]  shift_amt;
	btn_sel_t    btn;
	logic        do_step;
	logic        is_read;
	logic        is_write;
	logic        is_press;
	logic        is_release;

	assign do_step    = ctrl.valid && ctrl.advance;
	assign is_read    = item_s1.command == CMD_READ;
	assign is_write   = item_s1.command == CMD_WRITE;
	assign is_press   = item_s1.command == CMD_PRESS;
	assign is_release = item_s1.command == CMD_RELEASE;
	assign btn        = button_map(item_s1.button_code);

	// Barrel shift: right by eight minus the offset
	assign shift_amt = 4'd8 - {1'b0, shift_offset_q};
	assign shifted   = shift_word_q >> shift_amt;

	// Build the read result and the latch values after this request
	always_comb begin
		res_next = '0;
		if (is_read) begin
			unique case (item_s1.port_number)
				PORT_FIXED:   begin res_next.read_data = port0_q;        res_next.read_hit = 1'b1; end
				PORT_BTN_ONE: begin res_next.read_data = buttons_one_q;  res_next.read_hit = 1'b1; end
				PORT_BTN_TWO: begin res_next.read_data = buttons_two_q;  res_next.read_hit = 1'b1; end
				PORT_SHIFT:   begin res_next.read_data = shifted[7:0];   res_next.read_hit = 1'b1; end
				default:      res_next.read_hit = 1'b0;
			endcase
		end
		res_next.sound_latch_a  = out_three_q;
		res_next.sound_latch_b  = out_five_q;
		res_next.latch_port_six = out_six_q;
		if (is_write) begin
			unique case (item_s1.port_number)
				PORT_OUT_A: res_next.sound_latch_a  = item_s1.write_data;
				PORT_OUT_B: res_next.sound_latch_b  = item_s1.write_data;
				PORT_OUT_C: res_next.latch_port_six = item_s1.write_data;
				default:    res_next.read_hit = 1'b0;
			endcase
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port0_q <= PORT0_RESET;
		end else if (cfg_we) begin
			port0_q <= cfg_wdata;
		end
	end

	// Update board state as the request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q   <= '0;
			shift_offset_q <= '0;
			buttons_one_q  <= BTN_ONE_RESET;
			buttons_two_q  <= '0;
			out_three_q    <= '0;
			out_five_q     <= '0;
			out_six_q      <= '0;
		end else if (do_step) begin
			if (is_write) begin
				unique case (item_s1.port_number)
					PORT_OFFSET:     shift_offset_q <= item_s1.write_data[2:0];
					PORT_OUT_A:      out_three_q    <= item_s1.write_data;
					PORT_SHIFT_LOAD: shift_word_q   <= {item_s1.write_data, shift_word_q[15:8]};
					PORT_OUT_B:      out_five_q     <= item_s1.write_data;
					PORT_OUT_C:      out_six_q      <= item_s1.write_data;
					default:         out_six_q      <= out_six_q;
				endcase
			end
			if (is_press) begin
				if (btn.to_one) buttons_one_q <= buttons_one_q | btn.mask;
				if (btn.to_two) buttons_two_q <= buttons_two_q | btn.mask;
			end
			if (is_release) begin
				if (btn.to_one) buttons_one_q <= buttons_one_q & ~btn.mask;
				if (btn.to_two) buttons_two_q <= buttons_two_q & ~btn.mask;
			end
		end
	end

endmodule

// File: src/asio_out_stage.sv
module asio_out_stage import asio_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_ctrl_t ctrl,
	input  res_item_t   res_next,
	output logic        advance,
	output logic        res_valid,
	input  logic        res_ready,
	output res_item_t   res
);

	logic      valid_s2;
	res_item_t res_s2;

	// Load a new result when the register is empty or being drained
	assign advance   = !valid_s2 || res_ready;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl.valid) begin
			res_s2 <= res_next;
		end
	end

endmodule

// File: src/arcade_shift_io_ports.sv
// Channel    | Handshake              | Payload
// cmd        | cmd_valid / cmd_ready  | cmd  (cmd_item_t)
// res        | res_valid / res_ready  | res  (res_item_t)
// cfg        | cfg_we                 | cfg_wdata (fixed word of port zero)
//
// A request is held in the request register, then its result is loaded into the result
// register and offered from there; one request is taken per cycle while the result
// side does not stall.
// The result register decides advance; a stalled result holds both stages.
// Reset is asynchronous: it empties both stages and returns the board state and the
// fixed word to their reset values (fixed word 14, bit 3 set in the first button latch).
module arcade_shift_io_ports import asio_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_item_t  cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_item_t  res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	stage_ctrl_t ctrl;
	cmd_item_t   item_s1;
	res_item_t   res_next;
	logic        advance;

	asio_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.advance   (advance),
		.ctrl      (ctrl),
		.item_s1   (item_s1)
	);

	asio_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.item_s1   (item_s1),
		.res_next  (res_next)
	);

	asio_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.res_next  (res_next),
		.advance   (advance),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// File: src/asio_checker.sv
module asio_checker import asio_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input res_item_t  res
);

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// A miss never carries data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.read_hit |-> res.read_data == 8'd0)
		else $error("read data without a hit");

	// Back-pressure only with a full, stalled result register
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("request refused with room in the pipeline");

	// A fresh result follows an accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result appeared without a matching request");

endmodule

bind arcade_shift_io_ports asio_checker u_asio_checker (.*);

// File: verif/arcade_shift_io_ports_tb.sv
`timescale 1ns / 100ps

module arcade_shift_io_ports_tb;
	import asio_pkg::*;

	localparam int  PHASES       = 4;
	localparam int  PHASE_ITEMS  = 212;
	localparam int  CALM_FIRST   = 40;
	localparam int  CALM_LAST    = 160;
	localparam int  IDLE_PCT     = 28;
	localparam int  SETTLE_CYCLES = 4;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  REPORT_MAX   = 10;
	localparam bit  TYPED        = 1'b1;
	localparam bit  PREDICTED    = 1'b0;

	typedef struct packed {
		bit        typed;
		cmd_item_t req;
		res_item_t want;
	} stim_row_t;

	localparam int DIR_ROWS = 25;

	// Directed requests: reset values and unmapped reads are typed in, the rest predicted
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{TYPED, '{CMD_READ, PORT_FIXED, 8'hFF, 4'hF}, '{8'h0E, 1'b1, 8'h00, 8'h00, 8'h00}},
		'{TYPED, '{CMD_READ, PORT_BTN_ONE, 8'h00, 4'h0}, '{8'h08, 1'b1, 8'h00, 8'h00, 8'h00}},
		'{TYPED, '{CMD_READ, PORT_BTN_TWO, 8'hFF, 4'hF}, '{8'h00, 1'b1, 8'h00, 8'h00, 8'h00}},
		'{TYPED, '{CMD_READ, PORT_SHIFT, 8'h00, 4'h0}, '{8'h00, 1'b1, 8'h00, 8'h00, 8'h00}},
		'{TYPED, '{CMD_READ, 8'hFF, 8'hFF, 4'hF}, '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00}},
		'{TYPED, '{CMD_READ, PORT_SHIFT_LOAD, 8'h00, 4'h0}, '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00}},
		'{PREDICTED, '{CMD_WRITE, PORT_OUT_A, 8'hFF, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_OUT_B, 8'hA5, 4'hF}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_OUT_C, 8'h5A, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_SHIFT_LOAD, 8'hFF, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_SHIFT_LOAD, 8'h81, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_OFFSET, 8'hFF, 4'h0}, '0},
		'{PREDICTED, '{CMD_READ, PORT_SHIFT, 8'h00, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_OFFSET, 8'hF8, 4'h0}, '0},
		'{PREDICTED, '{CMD_READ, PORT_SHIFT, 8'h00, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, PORT_FIXED, 8'h12, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, 8'd7, 8'h34, 4'h0}, '0},
		'{PREDICTED, '{CMD_WRITE, 8'hFF, 8'h00, 4'h0}, '0},
		'{PREDICTED, '{CMD_PRESS, 8'h00, 8'h00, BTN_COIN}, '0},
		'{PREDICTED, '{CMD_PRESS, 8'hFF, 8'hFF, BTN_P2_RIGHT}, '0},
		'{PREDICTED, '{CMD_PRESS, 8'h00, 8'h00, 4'hF}, '0},
		'{PREDICTED, '{CMD_READ, PORT_BTN_ONE, 8'h00, 4'h0}, '0},
		'{PREDICTED, '{CMD_RELEASE, 8'h00, 8'h00, BTN_COIN}, '0},
		'{PREDICTED, '{CMD_RELEASE, 8'h00, 8'h00, 4'h9}, '0},
		'{PREDICTED, '{CMD_READ, PORT_BTN_TWO, 8'h00, 4'h0}, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_ready;
	cmd_item_t  cmd;
	logic       res_valid;
	logic       res_ready;
	res_item_t  res;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	// Board state as predicted
	logic [7:0]  fixed_word;
	logic [15:0] shift_word;
	logic [2:0]  shift_offset;
	logic [7:0]  buttons_one;
	logic [7:0]  buttons_two;
	logic [7:0]  out_three;
	logic [7:0]  out_five;
	logic [7:0]  out_six;

	res_item_t pending_results [$];
	bit        calm;
	int        mismatches;
	int        cycle_count;
	int        n_reads, n_hits, n_writes, n_buttons, n_settings;

	arcade_shift_io_ports DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Advance the predicted board by one request and return its result
	function automatic res_item_t io_board_next(cmd_item_t c);
		res_item_t   r;
		logic [15:0] shifted;
		logic [7:0]  mask;
		bit          to_one, to_two;
		r = '0;
		mask = 8'h00;
		to_one = 1'b0;
		to_two = 1'b0;
		case (c.command)
			CMD_READ: begin
				r.read_hit = 1'b1;
				case (c.port_number)
					PORT_FIXED:   r.read_data = fixed_word;
					PORT_BTN_ONE: r.read_data = buttons_one;
					PORT_BTN_TWO: r.read_data = buttons_two;
					PORT_SHIFT: begin
						shifted = shift_word >> (8 - int'(shift_offset));
						r.read_data = shifted[7:0];
					end
					default: r.read_hit = 1'b0;
				endcase
			end
			CMD_WRITE: begin
				case (c.port_number)
					PORT_OFFSET:     shift_offset = c.write_data[2:0];
					PORT_OUT_A:      out_three = c.write_data;
					PORT_SHIFT_LOAD: shift_word = {c.write_data, shift_word[15:8]};
					PORT_OUT_B:      out_five = c.write_data;
					PORT_OUT_C:      out_six = c.write_data;
					default: ;
				endcase
			end
			default: begin
				case (c.button_code)
					BTN_COIN:     begin to_one = 1'b1; mask = 8'h01; end
					BTN_P2_START: begin to_one = 1'b1; mask = 8'h02; end
					BTN_P1_START: begin to_one = 1'b1; mask = 8'h04; end
					BTN_P1_SHOOT: begin to_one = 1'b1; mask = 8'h10; end
					BTN_P1_LEFT:  begin to_one = 1'b1; mask = 8'h20; end
					BTN_P1_RIGHT: begin to_one = 1'b1; mask = 8'h40; end
					BTN_P2_SHOOT: begin to_two = 1'b1; mask = 8'h10; end
					BTN_P2_LEFT:  begin to_two = 1'b1; mask = 8'h20; end
					BTN_P2_RIGHT: begin to_two = 1'b1; mask = 8'h40; end
					default: ;
				endcase
				if (c.command == CMD_PRESS) begin
					if (to_one) buttons_one = buttons_one | mask;
					if (to_two) buttons_two = buttons_two | mask;
				end else begin
					if (to_one) buttons_one = buttons_one & ~mask;
					if (to_two) buttons_two = buttons_two & ~mask;
				end
			end
		endcase
		r.sound_latch_a  = out_three;
		r.sound_latch_b  = out_five;
		r.latch_port_six = out_six;
		return r;
	endfunction

	// Mostly mapped ports and known buttons, with some of the full range
	function automatic cmd_item_t random_request();
		cmd_item_t c;
		c.command = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 85)
			c.port_number = 8'($urandom_range(0, 7));
		else
			c.port_number = 8'($urandom);
		c.write_data = 8'($urandom);
		if ($urandom_range(0, 99) < 85)
			c.button_code = 4'($urandom_range(0, 8));
		else
			c.button_code = 4'($urandom);
		return c;
	endfunction

	// Offer one request, hold it until taken, then queue its expected result
	task automatic send_request(input cmd_item_t c, input bit typed, input res_item_t want);
		res_item_t predicted;
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			do @(negedge clk); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		predicted = io_board_next(c);
		pending_results.push_back(typed ? want : predicted);
		case (c.command)
			CMD_READ: begin
				n_reads++;
				if (predicted.read_hit) n_hits++;
			end
			CMD_WRITE: n_writes++;
			default:   n_buttons++;
		endcase
		@(negedge clk);
	endtask

	// Drain the block, then load a new fixed word
	task automatic set_fixed_word(input logic [7:0] value);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we     <= 1'b0;
		fixed_word = value;
		n_settings++;
	endtask

	// Result side stalls at random, except in the calm stretch; held low in reset
	always @(negedge clk) begin
		res_ready <= arst_n && (calm || ($urandom_range(0, 99) >= IDLE_PCT));
	end

	// Compare each result taken with the oldest expectation
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result %h at cycle %0d", res, cycle_count);
			end else begin
				want = pending_results.pop_front();
				if (res.read_data !== want.read_data || res.read_hit !== want.read_hit
						|| res.sound_latch_a !== want.sound_latch_a
						|| res.sound_latch_b !== want.sound_latch_b
						|| res.latch_port_six !== want.latch_port_six) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch at cycle %0d: data %h/%h hit %b/%b a %h/%h b %h/%h six %h/%h",
							cycle_count, want.read_data, res.read_data, want.read_hit,
							res.read_hit, want.sound_latch_a, res.sound_latch_a,
							want.sound_latch_b, res.sound_latch_b,
							want.latch_port_six, res.latch_port_six);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[arcade_shift_io_ports] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		calm         = 1'b0;
		fixed_word   = PORT0_RESET;
		shift_word   = '0;
		shift_offset = '0;
		buttons_one  = BTN_ONE_RESET;
		buttons_two  = '0;
		out_three    = '0;
		out_five     = '0;
		out_six      = '0;

		// Hold reset, release on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int i = 0; i < DIR_ROWS; i++)
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		// Random phases, each under its own fixed word
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       set_fixed_word(8'h00);
				1:       set_fixed_word(8'hFF);
				default: set_fixed_word(8'($urandom));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				calm = (p == 1) && (i >= CALM_FIRST) && (i < CALM_LAST);
				send_request(random_request(), PREDICTED, '0);
			end
			calm = 1'b0;
		end

		// Drain and let the pipeline settle
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d reads (%0d on mapped ports), %0d writes, %0d button events",
			n_reads, n_hits, n_writes, n_buttons);
		$display("across %0d fixed-word settings, %0d mismatches", n_settings + 1, mismatches);
		if (mismatches == 0)
			$display("[arcade_shift_io_ports] OK");
		else
			$display("[arcade_shift_io_ports] ERROR");
		$finish;
	end

endmodule
